// ----- rtl/cau_pkg.sv -----
// Shared types, operation codes, saturation and division helpers for the complex arithmetic unit.
package cau_pkg;

   // Operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // One lane (real or imaginary) of the long division
   typedef struct packed {
      logic        neg;
      logic        ovf;
      logic [63:0] rem;
      logic [31:0] dvd;
      logic [31:0] quo;
   } lane_type;

   // Word carried down the division pipeline
   typedef struct packed {
      logic [1:0]  op;
      logic        dz;
      logic [31:0] res_re;
      logic [31:0] res_im;
      logic [63:0] den;
      lane_type    re;
      lane_type    im;
   } dstage_type;

   // Clamp a 33-bit two's complement sum to 32 bits
   function automatic logic [31:0] sat33(input logic [32:0] s);
      logic [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? SAT_NEG : SAT_POS;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   // Sign and magnitude to a clamped 32-bit two's complement value
   function automatic logic [31:0] sat_signmag(input logic neg, input logic [63:0] mag);
      logic [31:0] r;
      logic [63:0] nm;
      nm = 64'd0 - mag;
      if (neg) begin
         r = (mag >= 64'h8000_0000) ? SAT_NEG : nm[31:0];
      end else begin
         r = (mag > 64'h7FFF_FFFF) ? SAT_POS : mag[31:0];
      end
      return r;
   endfunction

   // One restoring division step: one quotient bit
   function automatic lane_type div_step(input lane_type l, input logic [63:0] den);
      lane_type    r;
      logic [64:0] t;
      logic [64:0] d;
      logic        ge;
      r  = l;
      t  = {l.rem, l.dvd[31]};
      ge = (t >= {1'b0, den});
      d  = t - {1'b0, den};
      r.rem = ge ? d[63:0] : t[63:0];
      r.dvd = {l.dvd[30:0], 1'b0};
      r.quo = {l.quo[30:0], ge};
      return r;
   endfunction

   // Round the quotient to nearest, ties away, and clamp
   function automatic logic [31:0] div_finish(input lane_type l, input logic [63:0] den);
      logic        rb;
      logic [32:0] q;
      logic [31:0] r;
      rb = ({l.rem, 1'b0} >= {1'b0, den});
      q  = {1'b0, l.quo} + {32'd0, rb};
      if (l.ovf) begin
         r = l.neg ? SAT_NEG : SAT_POS;
      end else begin
         r = sat_signmag(l.neg, {31'd0, q});
      end
      return r;
   endfunction

endpackage

// ----- rtl/complex_arith_unit.sv -----
// Throughput: one word per cycle while the response is not stalled. Products, sums, magnitudes and
// the division setup take four stages, the quotient takes 32 one-bit restoring stages, then a
// round/clamp output stage. The whole pipeline advances together; it halts only while the response
// is stalled.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
// Top level of the pipelined complex add/subtract/multiply/divide unit.
module complex_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_a_real,
   input  logic signed [31:0] req_a_imag,
   input  logic signed [31:0] req_b_real,
   input  logic signed [31:0] req_b_imag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_result_real,
   output logic [31:0]        rsp_result_imag,
   output logic               rsp_divide_by_zero
);

   localparam int SH     = 32 - FRAC_BITS;
   localparam int NSTEPS = 32;

   logic adv;

   // stage 1: products and add/subtract
   logic               v1_ff;
   logic [1:0]         op1_ff;
   logic signed [63:0] prr_ff, pii_ff, pri_ff, pir_ff, drr_ff, dii_ff;
   logic [32:0]        sum_re1, sum_im1;
   logic [31:0]        as_re1_ff, as_im1_ff, as_re1_in, as_im1_in;

   // stage 2: numerator sums and denominator
   logic               v2_ff;
   logic [1:0]         op2_ff;
   logic signed [64:0] sre_ff, sim_ff, sre_in, sim_in;
   logic [63:0]        den2_ff, den2_in;
   logic [31:0]        as_re2_ff, as_im2_ff;

   // stage 3: sign and magnitude
   logic               v3_ff;
   logic [1:0]         op3_ff;
   logic               nre_ff, nim_ff, nre_in, nim_in;
   logic [64:0]        neg_re, neg_im;
   logic [63:0]        mre_ff, mim_ff, mre_in, mim_in;
   logic [63:0]        den3_ff;
   logic               dz3_ff, dz3_in;
   logic [31:0]        as_re3_ff, as_im3_ff;

   // division setup and product rounding
   logic [63:0]         rnd_re, rnd_im, shl_re, shl_im;
   logic [95:0]         den_sh;
   cau_pkg::dstage_type ent_in;

   // division pipeline; entry 0 is the setup stage
   logic                dv_ff [0:NSTEPS];
   cau_pkg::dstage_type dp_ff [0:NSTEPS];
   cau_pkg::dstage_type fin_word;

   // output register
   logic        out_v_ff;
   logic [31:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic        out_dz_ff;

   // One quotient bit on both lanes of a word
   function automatic cau_pkg::dstage_type step_word(input cau_pkg::dstage_type w);
      cau_pkg::dstage_type r;
      r    = w;
      r.re = cau_pkg::div_step(w.re, w.den);
      r.im = cau_pkg::div_step(w.im, w.den);
      return r;
   endfunction

   // handshake: everything moves unless the response word is held
   assign adv       = !(out_v_ff && rsp_stall);
   assign req_stall = !adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k <= NSTEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
         for (int k = 1; k <= NSTEPS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         out_v_ff <= dv_ff[NSTEPS];
      end
   end

   // stage 1: saturated add/subtract
   always_comb begin
      if (req_operation == cau_pkg::OP_SUB) begin
         sum_re1 = {req_a_real[31], req_a_real} - {req_b_real[31], req_b_real};
         sum_im1 = {req_a_imag[31], req_a_imag} - {req_b_imag[31], req_b_imag};
      end else begin
         sum_re1 = {req_a_real[31], req_a_real} + {req_b_real[31], req_b_real};
         sum_im1 = {req_a_imag[31], req_a_imag} + {req_b_imag[31], req_b_imag};
      end
      as_re1_in = cau_pkg::sat33(sum_re1);
      as_im1_in = cau_pkg::sat33(sum_im1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff    <= req_operation;
         prr_ff    <= 64'(req_a_real) * 64'(req_b_real);
         pii_ff    <= 64'(req_a_imag) * 64'(req_b_imag);
         pri_ff    <= 64'(req_a_real) * 64'(req_b_imag);
         pir_ff    <= 64'(req_a_imag) * 64'(req_b_real);
         drr_ff    <= 64'(req_b_real) * 64'(req_b_real);
         dii_ff    <= 64'(req_b_imag) * 64'(req_b_imag);
         as_re1_ff <= as_re1_in;
         as_im1_ff <= as_im1_in;
      end
   end

   // stage 2: exact numerators; divide uses a times conj(b)
   always_comb begin
      if (op1_ff == cau_pkg::OP_DIV) begin
         sre_in = 65'(prr_ff) + 65'(pii_ff);
         sim_in = 65'(pir_ff) - 65'(pri_ff);
      end else begin
         sre_in = 65'(prr_ff) - 65'(pii_ff);
         sim_in = 65'(pri_ff) + 65'(pir_ff);
      end
      den2_in = drr_ff + dii_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff    <= op1_ff;
         sre_ff    <= sre_in;
         sim_ff    <= sim_in;
         den2_ff   <= den2_in;
         as_re2_ff <= as_re1_ff;
         as_im2_ff <= as_im1_ff;
      end
   end

   // stage 3: sign and magnitude, zero denominator
   always_comb begin
      nre_in = sre_ff[64];
      nim_in = sim_ff[64];
      neg_re = 65'd0 - sre_ff;
      neg_im = 65'd0 - sim_ff;
      mre_in = nre_in ? neg_re[63:0] : sre_ff[63:0];
      mim_in = nim_in ? neg_im[63:0] : sim_ff[63:0];
      dz3_in = (den2_ff == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op3_ff    <= op2_ff;
         nre_ff    <= nre_in;
         nim_ff    <= nim_in;
         mre_ff    <= mre_in;
         mim_ff    <= mim_in;
         den3_ff   <= den2_ff;
         dz3_ff    <= dz3_in;
         as_re3_ff <= as_re2_ff;
         as_im3_ff <= as_im2_ff;
      end
   end

   // stage 4: product rounding, division overflow check and first remainder
   always_comb begin
      rnd_re     = mre_ff + (64'd1 << (FRAC_BITS - 1));
      rnd_im     = mim_ff + (64'd1 << (FRAC_BITS - 1));
      shl_re     = mre_ff << FRAC_BITS;
      shl_im     = mim_ff << FRAC_BITS;
      den_sh     = {32'd0, den3_ff} << SH;
      ent_in.op  = op3_ff;
      ent_in.dz  = dz3_ff && (op3_ff == cau_pkg::OP_DIV);
      ent_in.den = den3_ff;
      case (op3_ff)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
            ent_in.res_re = as_re3_ff;
            ent_in.res_im = as_im3_ff;
         end
         cau_pkg::OP_MUL: begin
            ent_in.res_re = cau_pkg::sat_signmag(nre_ff, rnd_re >> FRAC_BITS);
            ent_in.res_im = cau_pkg::sat_signmag(nim_ff, rnd_im >> FRAC_BITS);
         end
         default: begin
            ent_in.res_re = 32'd0;
            ent_in.res_im = 32'd0;
         end
      endcase
      // quotient of 2^32 or more saturates either way
      ent_in.re.neg = nre_ff;
      ent_in.re.ovf = ({32'd0, mre_ff} >= den_sh);
      ent_in.re.rem = mre_ff >> SH;
      ent_in.re.dvd = shl_re[31:0];
      ent_in.re.quo = 32'd0;
      ent_in.im.neg = nim_ff;
      ent_in.im.ovf = ({32'd0, mim_ff} >= den_sh);
      ent_in.im.rem = mim_ff >> SH;
      ent_in.im.dvd = shl_im[31:0];
      ent_in.im.quo = 32'd0;
   end

   // restoring division, one bit per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         dp_ff[0] <= ent_in;
         for (int k = 1; k <= NSTEPS; k++) begin
            dp_ff[k] <= step_word(dp_ff[k-1]);
         end
      end
   end

   // output stage: round and clamp quotients, pass other results
   always_comb begin
      fin_word = dp_ff[NSTEPS];
      if (fin_word.op == cau_pkg::OP_DIV && !fin_word.dz) begin
         out_re_in = cau_pkg::div_finish(fin_word.re, fin_word.den);
         out_im_in = cau_pkg::div_finish(fin_word.im, fin_word.den);
      end else begin
         out_re_in = fin_word.res_re;
         out_im_in = fin_word.res_im;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
         out_dz_ff <= fin_word.dz;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_result_real    = out_re_ff;
   assign rsp_result_imag    = out_im_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule

// ----- rtl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit, bound to its top level.
module cau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_real,
   input logic [31:0] rsp_result_imag,
   input logic        rsp_divide_by_zero
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_real)
         && $stable(rsp_result_imag) && $stable(rsp_divide_by_zero))
      else $error("stalled response word changed");

   // divide by zero returns zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_real == 32'd0
         && rsp_result_imag == 32'd0)
      else $error("divide by zero with nonzero result");

   // the request side halts only behind a stalled response
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_real    (rsp_result_real),
   .rsp_result_imag    (rsp_result_imag),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

// ----- test/tb_complex_arith_unit.sv -----
// Testbench for the pipelined complex add/subtract/multiply/divide unit.
`timescale 1ns / 100ps

module tb_complex_arith_unit;

   localparam int FRAC     = 16;
   localparam int LATENCY  = 37;
   localparam int HOLD_LEN = 150;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        dz;
   } cplx_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_operation;
   logic signed [31:0] req_a_real;
   logic signed [31:0] req_a_imag;
   logic signed [31:0] req_b_real;
   logic signed [31:0] req_b_imag;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_result_real;
   logic [31:0]        rsp_result_imag;
   logic               rsp_divide_by_zero;

   cplx_result_type expected_results[$];
   int              mismatch_count = 0;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_cycles;
   logic            hold_go;

   complex_arith_unit #(.FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation),
      .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_real(rsp_result_real), .rsp_result_imag(rsp_result_imag),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   // Clock
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Clamp a signed value to 32 bits
   function automatic logic [31:0] clamp32(input logic signed [127:0] v);
      logic [31:0] r;
      if (v > 128'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -128'sh8000_0000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // Exact product sum rounded to nearest, ties away from zero
   function automatic logic [31:0] round_prod(input logic signed [127:0] s);
      logic        neg;
      logic [127:0] mag;
      neg = s < 0;
      mag = neg ? -s : s;
      mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
      return clamp32(neg ? -$signed(mag) : $signed(mag));
   endfunction

   // Exact quotient num*2^FRAC/den, rounded to nearest, ties away from zero
   function automatic logic [31:0] round_quot(input logic signed [127:0] num,
                                               input logic [127:0] den);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] q;
      logic [127:0] rem;
      neg = num < 0;
      mag = neg ? -num : num;
      mag = mag << FRAC;
      q   = mag / den;
      rem = mag % den;
      if ((rem << 1) >= den) q = q + 1;
      if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
      return clamp32(neg ? -$signed(q) : $signed(q));
   endfunction

   // Expected complex result for one word
   function automatic cplx_result_type complex_result(input logic [1:0] op,
         input logic signed [31:0] ar, input logic signed [31:0] ai,
         input logic signed [31:0] br, input logic signed [31:0] bi);
      cplx_result_type     r;
      logic signed [127:0] xr, xi, yr, yi;
      logic [127:0]        den;
      xr = ar; xi = ai; yr = br; yi = bi;
      r = '0;
      case (op)
         cau_pkg::OP_ADD: begin
            r.re = clamp32(xr + yr);
            r.im = clamp32(xi + yi);
         end
         cau_pkg::OP_SUB: begin
            r.re = clamp32(xr - yr);
            r.im = clamp32(xi - yi);
         end
         cau_pkg::OP_MUL: begin
            r.re = round_prod(xr * yr - xi * yi);
            r.im = round_prod(xr * yi + xi * yr);
         end
         default: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               r.re = round_quot(xr * yr + xi * yi, den);
               r.im = round_quot(xi * yr - xr * yi, den);
            end
         end
      endcase
      return r;
   endfunction

   // Mismatch report
   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Send one word, holding it until accepted
   task automatic send_word(input logic [1:0] op, input logic [31:0] ar,
                            input logic [31:0] ai, input logic [31:0] br,
                            input logic [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_a_real    <= ar;
      req_a_imag    <= ai;
      req_b_real    <= br;
      req_b_imag    <= bi;
      expected_results.push_back(complex_result(op, ar, ai, br, bi));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver stall pattern, with one long hold-off once requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_go && hold_cycles < HOLD_LEN) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      cplx_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response word with nothing expected");
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_real !== e.re)
               report_mismatch($sformatf("real %h, expected %h", rsp_result_real, e.re));
            if (rsp_result_imag !== e.im)
               report_mismatch($sformatf("imag %h, expected %h", rsp_result_imag, e.im));
            if (rsp_divide_by_zero !== e.dz)
               report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                         rsp_divide_by_zero, e.dz));
         end
      end
   end

   function automatic logic [31:0] rand_field();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
         3: v = 32'($signed($urandom_range(512)) - 256);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic [31:0] ext[6];
      ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
              32'h0001_0000, 32'hFFFF_0000};
      for (int op = 0; op < 4; op++) begin
         send_word(op[1:0], ext[0], ext[1], ext[0], ext[1]);
         send_word(op[1:0], ext[1], ext[0], ext[1], ext[1]);
         send_word(op[1:0], ext[4], ext[5], ext[3], ext[2]);
         send_word(op[1:0], ext[0], ext[0], ext[5], ext[4]);
      end
      // Zero denominator, and a tiny one
      send_word(cau_pkg::OP_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0, 32'h0);
      send_word(cau_pkg::OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
      send_word(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
      send_word(cau_pkg::OP_DIV, 32'h0000_8000, 32'h0, 32'h0002_0000, 32'h0);
      // Ties in rounding
      send_word(cau_pkg::OP_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
      send_word(cau_pkg::OP_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0);
   endtask

   task automatic test_random(input int n);
      logic [31:0] br, bi;
      for (int i = 0; i < n; i++) begin
         br = rand_field();
         bi = rand_field();
         if ($urandom_range(19) == 0) begin
            br = '0; bi = '0;
         end
         send_word(2'($urandom_range(3)), rand_field(), rand_field(), br, bi);
      end
   endtask

   task automatic test_backpressure();
      hold_go <= 1'b1;
      test_random(80);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   initial begin
      hold_go        = 1'b0;
      send_idle_pct  = 33;
      recv_idle_pct  = 63;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = cau_pkg::OP_ADD;
      req_a_real     = '0;
      req_a_imag     = '0;
      req_b_real     = '0;
      req_b_imag     = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(240);
      send_idle_pct = 63;
      recv_idle_pct = 33;
      test_random(240);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(240);
      wait_drained();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cau_pkg.sv
rtl/complex_arith_unit.sv
rtl/cau_checker.sv
test/tb_complex_arith_unit.sv
